FILE: design/bsb_pkg.sv
package bsb_pkg;

   // request kinds
   localparam logic [1:0] REQ_CMD_WRITE  = 2'd0;
   localparam logic [1:0] REQ_DATA_WRITE = 2'd1;
   localparam logic [1:0] REQ_DATA_READ  = 2'd2;
   localparam logic [1:0] REQ_RX_BYTE    = 2'd3;

   // command codes
   localparam logic [7:0] CMD_SET_BAUD = 8'd1;
   localparam logic [7:0] CMD_GET_BAUD = 8'd2;
   localparam logic [7:0] CMD_CLR_RX   = 8'd3;
   localparam logic [7:0] CMD_CLR_TX   = 8'd4;
   localparam logic [7:0] CMD_FLUSH_TX = 8'd5;
   localparam logic [7:0] CMD_CRC_ON   = 8'd6;
   localparam logic [7:0] CMD_CRC_OFF  = 8'd7;
   localparam logic [7:0] CMD_RX_FILL  = 8'd8;
   localparam logic [7:0] CMD_POP_RX   = 8'd9;
   localparam logic [7:0] CMD_PUSH_TX  = 8'd10;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [3:0]  BAUD_MAX   = 4'd9;
   localparam logic [3:0]  BAUD_RESET = 4'd5;

   // one captured request
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       slot;
   } req_item_type;

   // modbus crc-16 over one byte, reflected, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i,
                                              input logic [7:0]  byte_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, byte_i};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: design/bsb_ram.sv
module bsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bus_serial_bridge_with_crc16_unit.sv
// Bus to serial bridge with modbus crc-16 append.
// Request channel (req_valid / req_stall): req_type selects a command write,
// a data write, a data read or a received serial byte; req_data_byte carries
// the byte; req_tx_slot says the transmitter can take a byte this request.
// Response channel (rsp_valid / rsp_stall): exactly one response per request,
// with the read reply, the byte sent to the line, drive enable, busy and the
// current baud index.
// An accepted request is held in req_ff while the rx and tx buffer memory
// reads issued at accept are registered; its response is registered by the
// read-modify-write step once the output register is free. No new request
// is taken until that step has executed the current one.
// While a response waits under rsp_stall the next request is still taken,
// but it is held in the execute step until the output register frees up.
// Reset (synchronous, active high) empties both buffers, restores crc to
// ffff, crc append on, baud index 5; buffer contents are left as they are.
module bus_serial_bridge_with_crc16_unit #(
   parameter int RX_DEPTH = 256,
   parameter int TX_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_tx_slot,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_serial_byte,
   output logic       rsp_serial_valid,
   output logic       rsp_drive_enable,
   output logic       rsp_busy_res,
   output logic [3:0] rsp_baud_index
);

   localparam int RW = $clog2(RX_DEPTH);
   localparam int TW = $clog2(TX_DEPTH);
   localparam int FW = $clog2(TX_DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   bsb_pkg::req_item_type req_ff, req_in;

   logic [7:0]    last_cmd_ff, last_cmd_in;
   logic          crc_on_ff, crc_on_in;
   logic [3:0]    baud_ff, baud_in;
   logic [RW-1:0] rx_wr_ptr_ff, rx_wr_ptr_in;
   logic [RW-1:0] rx_rd_ptr_ff, rx_rd_ptr_in;
   logic [FW-1:0] tx_fill_ff, tx_fill_in;
   logic [FW-1:0] tx_send_ptr_ff, tx_send_ptr_in;
   logic [15:0]   crc_ff, crc_in;
   logic          crc_app_ff, crc_app_in;
   logic          sending_ff, sending_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic       rsp_read_valid_ff, rsp_read_valid_in;
   logic [7:0] rsp_serial_byte_ff, rsp_serial_byte_in;
   logic       rsp_serial_valid_ff, rsp_serial_valid_in;
   logic       rsp_drive_ff, rsp_drive_in;
   logic       rsp_busy_ff, rsp_busy_in;
   logic [3:0] rsp_baud_ff, rsp_baud_in;

   logic          accept;
   logic          exec_go;
   logic          out_free;
   logic          rx_we, tx_we;
   logic [7:0]    rx_wdata, tx_wdata;
   logic [7:0]    rx_rdata, tx_rdata;
   logic [RW:0]   rx_fill;
   logic [RW-1:0] rx_wr_next, rx_rd_next;
   logic [FW-1:0] send_next;
   logic [FW-1:0] crc_pos;

   // output register is free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign exec_go   = (state_ff == ST_EXEC) && out_free;

   // buffer memories, read issued at accept
   bsb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_wr_ptr_ff),
      .wr_data (rx_wdata),
      .rd_en   (accept),
      .rd_addr (rx_rd_ptr_ff),
      .rd_data (rx_rdata)
   );

   bsb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_fill_ff[TW-1:0]),
      .wr_data (tx_wdata),
      .rd_en   (accept),
      .rd_addr (tx_send_ptr_ff[TW-1:0]),
      .rd_data (tx_rdata)
   );

   // ring pointer helpers
   assign rx_wr_next = (rx_wr_ptr_ff == RW'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr_ff + 1'b1;
   assign rx_rd_next = (rx_rd_ptr_ff == RW'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr_ff + 1'b1;
   assign rx_fill    = (rx_wr_ptr_ff >= rx_rd_ptr_ff)
                     ? {1'b0, rx_wr_ptr_ff} - {1'b0, rx_rd_ptr_ff}
                     : {1'b0, rx_wr_ptr_ff} + (RW+1)'(RX_DEPTH) - {1'b0, rx_rd_ptr_ff};
   assign send_next  = tx_send_ptr_ff + 1'b1;
   assign crc_pos    = tx_fill_ff - FW'(2);

   // request capture and sequencing
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in.kind = req_type;
               req_in.data = req_data_byte;
               req_in.slot = req_tx_slot;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // read-modify-write of bridge state
   always_comb begin
      last_cmd_in    = last_cmd_ff;
      crc_on_in      = crc_on_ff;
      baud_in        = baud_ff;
      rx_wr_ptr_in   = rx_wr_ptr_ff;
      rx_rd_ptr_in   = rx_rd_ptr_ff;
      tx_fill_in     = tx_fill_ff;
      tx_send_ptr_in = tx_send_ptr_ff;
      crc_in         = crc_ff;
      crc_app_in     = crc_app_ff;
      sending_in     = sending_ff;
      rx_we          = 1'b0;
      rx_wdata       = req_ff.data;
      tx_we          = 1'b0;
      tx_wdata       = req_ff.data;

      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_read_data_in    = rsp_read_data_ff;
      rsp_read_valid_in   = rsp_read_valid_ff;
      rsp_serial_byte_in  = rsp_serial_byte_ff;
      rsp_serial_valid_in = rsp_serial_valid_ff;
      rsp_drive_in        = rsp_drive_ff;
      rsp_busy_in         = rsp_busy_ff;
      rsp_baud_in         = rsp_baud_ff;

      if (exec_go) begin
         rsp_valid_in        = 1'b1;
         rsp_read_data_in    = 8'd0;
         rsp_read_valid_in   = 1'b0;
         rsp_serial_byte_in  = 8'd0;
         rsp_serial_valid_in = 1'b0;
         rsp_busy_in         = 1'b0;

         // bus side or received byte
         priority if (req_ff.kind == bsb_pkg::REQ_RX_BYTE) begin
            rx_we        = 1'b1;
            rx_wr_ptr_in = rx_wr_next;
         end else if (sending_ff) begin
            rsp_busy_in = 1'b1;
         end else if (req_ff.kind == bsb_pkg::REQ_CMD_WRITE) begin
            last_cmd_in = req_ff.data;
            priority case (req_ff.data)
               bsb_pkg::CMD_CLR_RX: begin
                  rx_wr_ptr_in = '0;
                  rx_rd_ptr_in = '0;
               end
               bsb_pkg::CMD_CLR_TX: begin
                  tx_fill_in     = '0;
                  tx_send_ptr_in = '0;
                  crc_in         = bsb_pkg::CRC_INIT;
                  crc_app_in     = 1'b0;
               end
               bsb_pkg::CMD_FLUSH_TX: begin
                  tx_send_ptr_in = '0;
                  if (crc_on_ff && (tx_fill_ff <= FW'(TX_DEPTH - 2))) begin
                     // crc bytes are served from crc_ff at send time
                     tx_fill_in = tx_fill_ff + FW'(2);
                     crc_app_in = 1'b1;
                     sending_in = 1'b1;
                  end else if (tx_fill_ff != '0) begin
                     sending_in = 1'b1;
                  end else begin
                     tx_fill_in = '0;
                     crc_in     = bsb_pkg::CRC_INIT;
                     crc_app_in = 1'b0;
                  end
               end
               bsb_pkg::CMD_CRC_ON:  crc_on_in = 1'b1;
               bsb_pkg::CMD_CRC_OFF: crc_on_in = 1'b0;
               default: ;
            endcase
         end else if (req_ff.kind == bsb_pkg::REQ_DATA_WRITE) begin
            if (last_cmd_ff == bsb_pkg::CMD_SET_BAUD) begin
               baud_in = (req_ff.data > {4'd0, bsb_pkg::BAUD_MAX})
                       ? bsb_pkg::BAUD_MAX : req_ff.data[3:0];
            end else if (last_cmd_ff == bsb_pkg::CMD_PUSH_TX) begin
               if (tx_fill_ff < FW'(TX_DEPTH - 2)) begin
                  tx_we      = 1'b1;
                  tx_fill_in = tx_fill_ff + 1'b1;
                  crc_in     = bsb_pkg::crc16_byte(crc_ff, req_ff.data);
               end
            end
         end else begin
            // data read
            if (last_cmd_ff == bsb_pkg::CMD_GET_BAUD) begin
               rsp_read_data_in  = {4'd0, baud_ff};
               rsp_read_valid_in = 1'b1;
            end else if (last_cmd_ff == bsb_pkg::CMD_RX_FILL) begin
               rsp_read_data_in  = 8'(rx_fill);
               rsp_read_valid_in = 1'b1;
            end else if (last_cmd_ff == bsb_pkg::CMD_POP_RX) begin
               rsp_read_valid_in = 1'b1;
               if (rx_wr_ptr_ff != rx_rd_ptr_ff) begin
                  rsp_read_data_in = rx_rdata;
                  rx_rd_ptr_in     = rx_rd_next;
               end
            end
         end

         // transmit one byte per slot while sending
         if (sending_ff && req_ff.slot) begin
            rsp_serial_valid_in = 1'b1;
            if (crc_app_ff && (tx_send_ptr_ff >= crc_pos)) begin
               rsp_serial_byte_in = (tx_send_ptr_ff == crc_pos) ? crc_ff[7:0] : crc_ff[15:8];
            end else begin
               rsp_serial_byte_in = tx_rdata;
            end
            tx_send_ptr_in = send_next;
            if (send_next >= tx_fill_ff) begin
               tx_fill_in     = '0;
               tx_send_ptr_in = '0;
               crc_in         = bsb_pkg::CRC_INIT;
               crc_app_in     = 1'b0;
               sending_in     = 1'b0;
            end
         end

         rsp_drive_in = sending_ff || sending_in;
         rsp_baud_in  = baud_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_cmd_ff    <= 8'd0;
         crc_on_ff      <= 1'b1;
         baud_ff        <= bsb_pkg::BAUD_RESET;
         rx_wr_ptr_ff   <= '0;
         rx_rd_ptr_ff   <= '0;
         tx_fill_ff     <= '0;
         tx_send_ptr_ff <= '0;
         crc_ff         <= bsb_pkg::CRC_INIT;
         crc_app_ff     <= 1'b0;
         sending_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_cmd_ff    <= last_cmd_in;
         crc_on_ff      <= crc_on_in;
         baud_ff        <= baud_in;
         rx_wr_ptr_ff   <= rx_wr_ptr_in;
         rx_rd_ptr_ff   <= rx_rd_ptr_in;
         tx_fill_ff     <= tx_fill_in;
         tx_send_ptr_ff <= tx_send_ptr_in;
         crc_ff         <= crc_in;
         crc_app_ff     <= crc_app_in;
         sending_ff     <= sending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff              <= req_in;
      rsp_read_data_ff    <= rsp_read_data_in;
      rsp_read_valid_ff   <= rsp_read_valid_in;
      rsp_serial_byte_ff  <= rsp_serial_byte_in;
      rsp_serial_valid_ff <= rsp_serial_valid_in;
      rsp_drive_ff        <= rsp_drive_in;
      rsp_busy_ff         <= rsp_busy_in;
      rsp_baud_ff         <= rsp_baud_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_read_valid   = rsp_read_valid_ff;
   assign rsp_serial_byte  = rsp_serial_byte_ff;
   assign rsp_serial_valid = rsp_serial_valid_ff;
   assign rsp_drive_enable = rsp_drive_ff;
   assign rsp_busy_res     = rsp_busy_ff;
   assign rsp_baud_index   = rsp_baud_ff;

endmodule
